FILE: hw/rtl/isqrt_pkg.sv
// Shared types and constants for the integer square root block.
// Used by isqrt_ctrl, isqrt_dp and integer_square_root; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package isqrt_pkg;

  // Default radicand width and the fixed width of the root field.
  localparam int unsigned DefRadicandBits = 31;
  localparam int unsigned RootW           = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } isqrt_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new radicand and start the iteration
    logic step;       // settle one root bit
    logic publish;    // write a root into the output register
    logic pub_step;   // publish the result of this cycle's step, not the stored one
  } isqrt_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/isqrt_ctrl.sv
// Controller for the integer square root block: sequences one word through
// the bit iterations and manages the output register. Depends on isqrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isqrt_ctrl #(
  parameter int unsigned ROOT_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output isqrt_pkg::isqrt_cmd_t    cmd_o
);
  import isqrt_pkg::*;

  localparam int unsigned CntW = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(ROOT_BITS - 1);

  isqrt_state_e    state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  // The output register can take a word when empty or when its word leaves now.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
          cnt_d   = CntLast;
        end
      end
      ST_RUN: begin
        if (cnt_q == '0) begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (cnt_q == '0 && out_free) begin
          cmd_o.publish  = 1'b1;
          cmd_o.pub_step = 1'b1;
        end
      end
      ST_HOLD: begin
        cmd_o.publish = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_RUN && cnt_q == CntLast))
    else $error("accepted word did not start the iteration");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cnt_q != '0) |=>
      (state_q == ST_RUN && cnt_q == $past(cnt_q) - 1'b1))
    else $error("iteration counter skipped a step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || !out_stall_i))
    else $error("root published over a word still waiting");

  a_hold_needs_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD) |-> out_valid_q)
    else $error("holding a root while the output register is empty");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/isqrt_dp.sv
// Datapath for the integer square root block: remainder, partial root and
// place registers, one restoring step per cycle, output register. Uses isqrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isqrt_dp #(
  parameter int unsigned RADICAND_BITS = 31
) (
  input  wire logic                       clk_i,
  input  wire logic [RADICAND_BITS-1:0]   radicand_i,
  input  wire isqrt_pkg::isqrt_cmd_t      cmd_i,
  output logic [isqrt_pkg::RootW-1:0]     root_o
);
  import isqrt_pkg::*;

  localparam int unsigned RootBits = (RADICAND_BITS + 1) / 2;
  localparam int unsigned W        = 2 * RootBits;

  logic [W-1:0]        rem_q, rem_d;
  logic [W-1:0]        acc_q, acc_d;
  logic [W-1:0]        place_q, place_d;
  logic [W-1:0]        trial;
  logic                take;
  logic [W-1:0]        acc_step;
  logic [W-1:0]        acc_pub;
  logic [RootW-1:0]    root_q, root_d;

  assign trial    = acc_q + place_q;
  assign take     = (rem_q >= trial);
  assign acc_step = take ? ((acc_q >> 1) + place_q) : (acc_q >> 1);

  always_comb begin
    rem_d   = rem_q;
    acc_d   = acc_q;
    place_d = place_q;
    if (cmd_i.load) begin
      rem_d   = W'(radicand_i);
      acc_d   = '0;
      place_d = W'(1) << (W - 2);
    end else if (cmd_i.step) begin
      rem_d   = take ? (rem_q - trial) : rem_q;
      acc_d   = acc_step;
      place_d = place_q >> 2;
    end
  end

  assign acc_pub = cmd_i.pub_step ? acc_step : acc_q;

  // The finished root fits in RootBits bits; saturate it into the field.
  generate
    if (RootBits > RootW) begin : g_sat
      always_comb begin
        if (|acc_pub[RootBits-1:RootW]) begin
          root_d = '1;
        end else begin
          root_d = acc_pub[RootW-1:0];
        end
      end
    end else begin : g_ext
      always_comb begin
        root_d = RootW'(acc_pub[RootBits-1:0]);
      end
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    acc_q   <= acc_d;
    place_q <= place_d;
    if (cmd_i.publish) begin
      root_q <= root_d;
    end
  end

  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: hw/rtl/integer_square_root.sv
// Top level of the integer square root block: joins controller and datapath.
// Depends on isqrt_pkg, isqrt_ctrl and isqrt_dp.
//
// Usage:
// The input channel carries one radicand word per transfer (in_valid_i,
// in_stall_o, radicand_i); the output channel returns one root word, the
// floor of the square root, per radicand (out_valid_o, out_stall_i, root_o).
// A word moves at a rising edge where valid is high and stall is low.
// The root is found by the restoring digit-by-digit method, one root bit per
// cycle through a single add, compare and subtract stage; there are
// R = (RADICAND_BITS + 1) / 2 root bits (16 for the default 31-bit radicand).
// One word is worked on at a time, so the input takes no new word until the
// iteration of the last one is through and the block is idle again. The
// output register holds a finished root while the receiver stalls, and the
// next radicand may be accepted and iterated meanwhile; if that next root is
// done before the waiting one leaves, the block holds it and keeps stalling
// the input until the output register frees. Roots above 16 bits, possible
// only for radicands wider than 32 bits, saturate at all ones. Reset clears
// the controller and the output valid; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module integer_square_root #(
  parameter int unsigned RADICAND_BITS = isqrt_pkg::DefRadicandBits
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [RADICAND_BITS-1:0]  radicand_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [isqrt_pkg::RootW-1:0]    root_o
);
  import isqrt_pkg::*;

  // Number of root bits, which is also the number of iteration steps.
  localparam int unsigned RootBits = (RADICAND_BITS + 1) / 2;

  isqrt_cmd_t cmd;

  // The controller owns sequencing and the output valid flag.
  isqrt_ctrl #(
    .ROOT_BITS (RootBits)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // The datapath holds the remainder, partial root and output register.
  isqrt_dp #(
    .RADICAND_BITS (RADICAND_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .radicand_i (radicand_i),
    .cmd_i      (cmd),
    .root_o     (root_o)
  );

endmodule

`default_nettype wire

FILE: test/integer_square_root_tb.sv
// Self-checking testbench for integer_square_root: drives radicand words, predicts floor roots.
// Depends on isqrt_pkg and the integer_square_root RTL; needs no files or arguments.
`timescale 1ns / 1ps

module integer_square_root_tb;

  import isqrt_pkg::*;

  // The block is built at its default width, so no radicand bit lies above the range
  // that takes part in the computation.
  localparam int unsigned RadicandBits = DefRadicandBits;
  localparam int unsigned RootBits     = (RadicandBits + 1) / 2;
  localparam int unsigned Latency      = RootBits;
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned MaxReports   = 40;
  localparam int unsigned MaxRootInt   = 46340;

  typedef logic [RadicandBits-1:0] radicand_t;
  typedef logic [RootW-1:0]        root_t;

  // One entry for each radicand the block has taken and not yet answered.
  typedef struct {
    radicand_t radicand;
    root_t     root;
  } root_entry_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  radicand_t radicand_i;
  logic      out_valid_o;
  logic      out_stall_i;
  root_t     root_o;

  root_entry_t pending_roots[$];
  int unsigned error_count;
  int unsigned cycle_count;
  // Set for the last part of the run: no gaps on the input side and no stalls on the output.
  bit          full_rate;

  integer_square_root #(
    .RADICAND_BITS(RadicandBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .radicand_i (radicand_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .root_o     (root_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Restoring digit-by-digit square root. The trial value is the running root
  // (kept shifted up by the current bit position) plus the square of the bit under test.
  // When the remainder covers it, the bit is set and the trial is taken off.
  function automatic root_t floor_sqrt(input radicand_t value);
    logic [RadicandBits:0] remainder;
    logic [RadicandBits:0] partial;
    logic [RadicandBits:0] bit_square;
    logic [RadicandBits:0] trial;
    remainder  = {1'b0, value};
    partial    = '0;
    bit_square = {{RadicandBits{1'b0}}, 1'b1} << ((RootBits - 1) * 2);
    while (bit_square != 0) begin
      trial = partial + bit_square;
      if (remainder >= trial) begin
        remainder = remainder - trial;
        partial   = (partial >> 1) + bit_square;
      end else begin
        partial = partial >> 1;
      end
      bit_square = bit_square >> 2;
    end
    // Only a radicand wider than 32 bits could push the root past the output field.
    if (partial > {{(RadicandBits + 1 - RootW){1'b0}}, {RootW{1'b1}}}) begin
      partial = {{(RadicandBits + 1 - RootW){1'b0}}, {RootW{1'b1}}};
    end
    return partial[RootW-1:0];
  endfunction

  // Random radicands are weighted toward the places where the root steps up:
  // exact squares and the values just below them. The rest are full-range
  // values, values of random bit length, and small values.
  function automatic radicand_t pick_radicand();
    int unsigned r;
    radicand_t   value;
    case ($urandom_range(0, 5))
      0: value = radicand_t'($urandom);
      1: begin
        r     = $urandom_range(0, MaxRootInt);
        value = radicand_t'(r * r);
      end
      2: begin
        r     = $urandom_range(1, MaxRootInt);
        value = radicand_t'(r * r - 1);
      end
      3: begin
        // Largest radicand that still has root r.
        r     = $urandom_range(0, MaxRootInt - 1);
        value = radicand_t'(r * r + 2 * r);
      end
      4: value = radicand_t'($urandom) >> $urandom_range(1, RadicandBits - 1);
      default: value = radicand_t'($urandom_range(0, 300));
    endcase
    return value;
  endfunction

  // Offers one radicand word and holds it until the block takes it. The expected
  // root is queued at the edge of acceptance. An idle burst may follow, during which
  // the radicand lines carry junk so that only the valid qualifies the word.
  task automatic send_radicand(input radicand_t value);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    radicand_i <= value;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    pending_roots.push_back('{radicand: value, root: floor_sqrt(value)});
    if (!full_rate && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      radicand_i <= radicand_t'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Smallest, largest and boundary radicands: zero and one, the first few
  // squares and their neighbors, the largest square that fits, the all-ones
  // radicand, a lone top bit and alternating bit patterns.
  task automatic test_extremes();
    radicand_t directed[$];
    directed = '{
      0, 1, 2, 3, 4, 5, 8, 9, 15, 16, 24, 25, 255, 256,
      radicand_t'(MaxRootInt * MaxRootInt),
      radicand_t'(MaxRootInt * MaxRootInt - 1),
      radicand_t'(MaxRootInt * MaxRootInt + 1),
      {RadicandBits{1'b1}},
      radicand_t'(1) << (RadicandBits - 1),
      (radicand_t'(1) << (RadicandBits - 1)) - 1,
      radicand_t'(32'h5555_5555),
      radicand_t'(32'h2AAA_AAAA)
    };
    foreach (directed[i]) send_radicand(directed[i]);
  endtask

  task automatic test_random_radicands(input int unsigned count);
    repeat (count) send_radicand(pick_radicand());
  endtask

  // Visits the squares of random roots, each with its neighbors on either side,
  // so that each step of the root that it visits is crossed from both sides.
  task automatic test_square_steps(input int unsigned count);
    int unsigned r;
    repeat (count / 3) begin
      r = $urandom_range(1, MaxRootInt);
      send_radicand(radicand_t'(r * r - 1));
      send_radicand(radicand_t'(r * r));
      send_radicand(radicand_t'(r * r + 1));
    end
  endtask

  // Last part of the run: the input never idles and the output never stalls, so
  // the block is held at its best throughput.
  task automatic test_full_rate(input int unsigned count);
    full_rate = 1'b1;
    repeat (count) send_radicand(pick_radicand());
  endtask

  // Output side. Stall comes in random bursts, as do stretches without stall.
  // A burst already in progress when the full-rate phase starts is cut short.
  initial begin : drive_out_stall
    int unsigned burst;
    bit          stall_burst;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      burst       = $urandom_range(1, 16);
      stall_burst = ($urandom_range(0, 2) == 0);
      repeat (burst) begin
        @(negedge clk_i);
        out_stall_i <= stall_burst && !full_rate;
      end
    end
  end

  // Each root word leaving the block is checked against the oldest expectation.
  always @(posedge clk_i) begin : check_roots
    root_entry_t oldest;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_roots.size() == 0) begin
        error_count <= error_count + 1;
        if (error_count < MaxReports) begin
          $display("%0t: unexpected root word: expected none, actual %0d", $time, root_o);
        end
      end else begin
        oldest = pending_roots.pop_front();
        if (root_o !== oldest.root) begin
          error_count <= error_count + 1;
          if (error_count < MaxReports) begin
            $display("%0t: root of %0d: expected %0d, actual %0d",
                     $time, oldest.radicand, oldest.root, root_o);
          end
        end
      end
    end
  end

  // Watchdog for a block that hangs or loses words.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d roots outstanding", $time, pending_roots.size());
      $display("integer_square_root: mismatch");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    radicand_i  = '0;
    error_count = 0;
    cycle_count = 0;
    full_rate   = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_extremes();
    test_random_radicands(700);
    test_square_steps(300);
    test_full_rate(500);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk_i);
    // Any stray word the block might still produce would show up here.
    repeat (4 * Latency) @(posedge clk_i);

    if (error_count == 0) begin
      $display("integer_square_root: match");
    end else begin
      $display("integer_square_root: mismatch");
    end
    $finish;
  end

endmodule
